// ===== hw/rtl/qtpm_pkg.sv =====
// Types and constants for the quadrature tach period meter.
package qtpm_pkg;

	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int TPR_W = 8;
	localparam int PERIOD_W = 32;
	localparam int STAMP_W = 32;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_EDGE_A = 2'd0;
	localparam cmd_t CMD_EDGE_B = 2'd1;
	localparam cmd_t CMD_TIMER  = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_TPR_A = 2'd0;
	localparam cfg_idx_t REG_TPR_B = 2'd1;

	localparam logic [TPR_W-1:0] TPR_RESET = 8'd12;
	// bit0 = e, bit1 = f
	localparam logic [1:0] DIR_RESET = 2'b11;

endpackage

// ===== hw/rtl/quadrature_tach_period_meter_core.sv =====
// Quadrature tach period meter: input register, event update logic, result register.
// A beat is offered on the output once it enters the result register.
// Throughput: one event per cycle unless the output stalls; the state update
// sits between the input and result registers, so back-to-back events chain
// through it. Reset (arst_n low): state cleared, direction bits set to ones,
// ticks per revolution back to 12 on both channels, both channels empty.
module quadrature_tach_period_meter_core #(
	parameter int TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [qtpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qtpm_pkg::TPR_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [qtpm_pkg::CMD_W-1:0]          cmd,
	input  logic                                level_a,
	input  logic                                level_b,
	input  logic [qtpm_pkg::STAMP_W-1:0]        time_us,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                dir_e,
	output logic                                dir_f,
	output logic [qtpm_pkg::PERIOD_W-1:0]       period_a,
	output logic [qtpm_pkg::PERIOD_W-1:0]       period_b,
	output logic                                rev_done
);

	// configuration
	logic [qtpm_pkg::TPR_W-1:0] tpr_a_q, tpr_b_q;

	// input stage
	logic                          valid_s1;
	qtpm_pkg::cmd_t                cmd_s1;
	logic                          level_a_s1, level_b_s1;
	logic [TIME_BITS-1:0]          now_s1;

	// block state
	logic [1:0]                    prev_levels_q;
	logic                          levels_valid_q;
	logic [1:0]                    dir_bits_q;
	logic [qtpm_pkg::TPR_W-1:0]    tick_count_a_q, tick_count_b_q;
	logic [TIME_BITS-1:0]          rev_start_a_q, rev_start_b_q;
	logic                          started_a_q, started_b_q;
	logic [qtpm_pkg::PERIOD_W-1:0] period_a_q, period_b_q;
	logic                          alive_q;

	// result register
	logic                          out_valid_q;
	logic                          dir_e_q, dir_f_q, rev_done_q;
	logic [qtpm_pkg::PERIOD_W-1:0] period_a_out_q, period_b_out_q;

	logic advance;
	logic [TIME_BITS+qtpm_pkg::STAMP_W-1:0] stamp_ext;

	// next-state logic
	logic [1:0]                    prev_eff;
	logic                          dir_e_new, dir_f_new;
	logic [1:0]                    dir_bits_d;
	logic [1:0]                    prev_levels_d;
	logic                          levels_valid_d;
	logic [qtpm_pkg::TPR_W-1:0]    cnt_a_inc, cnt_b_inc, tick_count_a_d, tick_count_b_d;
	logic [TIME_BITS-1:0]          start_a_eff, start_b_eff, rev_start_a_d, rev_start_b_d;
	logic [TIME_BITS-1:0]          diff_a, diff_b;
	logic [TIME_BITS+qtpm_pkg::PERIOD_W-1:0] diff_a_ext, diff_b_ext;
	logic                          started_a_d, started_b_d;
	logic [qtpm_pkg::PERIOD_W-1:0] period_a_d, period_b_d;
	logic                          alive_d;
	logic                          done_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;

	assign out_valid = out_valid_q;
	assign dir_e     = dir_e_q;
	assign dir_f     = dir_f_q;
	assign period_a  = period_a_out_q;
	assign period_b  = period_b_out_q;
	assign rev_done  = rev_done_q;

	// timestamp zero-extended, then cut to the counter width
	assign stamp_ext = {{TIME_BITS{1'b0}}, time_us};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_a_q <= qtpm_pkg::TPR_RESET;
			tpr_b_q <= qtpm_pkg::TPR_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == qtpm_pkg::REG_TPR_A) begin
				tpr_a_q <= cfg_data;
			end
			if (cfg_index == qtpm_pkg::REG_TPR_B) begin
				tpr_b_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1     <= cmd;
			level_a_s1 <= level_a;
			level_b_s1 <= level_b;
			now_s1     <= stamp_ext[TIME_BITS-1:0];
		end
	end

	always_comb begin
		prev_eff  = levels_valid_q ? prev_levels_q : {level_b_s1, level_a_s1};
		dir_e_new = (!prev_eff[1] && !level_a_s1) || (!prev_eff[0] && level_b_s1) ||
			(prev_eff[1] && level_a_s1) || (prev_eff[0] && !level_b_s1);
		dir_f_new = (!prev_eff[0] && !level_b_s1) || (prev_eff[1] && !level_b_s1) ||
			(prev_eff[0] && level_b_s1) || (!prev_eff[1] && level_a_s1);

		start_a_eff = started_a_q ? rev_start_a_q : now_s1;
		start_b_eff = started_b_q ? rev_start_b_q : now_s1;
		cnt_a_inc   = tick_count_a_q + 1'b1;
		cnt_b_inc   = tick_count_b_q + 1'b1;
		diff_a      = now_s1 - start_a_eff;
		diff_b      = now_s1 - start_b_eff;
		diff_a_ext  = {{qtpm_pkg::PERIOD_W{1'b0}}, diff_a};
		diff_b_ext  = {{qtpm_pkg::PERIOD_W{1'b0}}, diff_b};

		dir_bits_d     = dir_bits_q;
		prev_levels_d  = prev_levels_q;
		levels_valid_d = levels_valid_q;
		tick_count_a_d = tick_count_a_q;
		tick_count_b_d = tick_count_b_q;
		rev_start_a_d  = rev_start_a_q;
		rev_start_b_d  = rev_start_b_q;
		started_a_d    = started_a_q;
		started_b_d    = started_b_q;
		period_a_d     = period_a_q;
		period_b_d     = period_b_q;
		alive_d        = alive_q;
		done_d         = 1'b0;

		unique case (cmd_s1)
			qtpm_pkg::CMD_EDGE_A: begin
				dir_bits_d     = {dir_f_new, dir_e_new};
				prev_levels_d  = {level_b_s1, level_a_s1};
				levels_valid_d = 1'b1;
				started_a_d    = 1'b1;
				rev_start_a_d  = start_a_eff;
				if (level_a_s1) begin
					alive_d = 1'b1;
					if (cnt_a_inc == tpr_a_q) begin
						period_a_d     = diff_a_ext[qtpm_pkg::PERIOD_W-1:0];
						rev_start_a_d  = now_s1;
						tick_count_a_d = '0;
						done_d         = 1'b1;
					end else begin
						tick_count_a_d = cnt_a_inc;
					end
				end
			end
			qtpm_pkg::CMD_EDGE_B: begin
				dir_bits_d     = {dir_f_new, dir_e_new};
				prev_levels_d  = {level_b_s1, level_a_s1};
				levels_valid_d = 1'b1;
				started_b_d    = 1'b1;
				rev_start_b_d  = start_b_eff;
				if (level_b_s1) begin
					if (cnt_b_inc == tpr_b_q) begin
						period_b_d     = diff_b_ext[qtpm_pkg::PERIOD_W-1:0];
						rev_start_b_d  = now_s1;
						tick_count_b_d = '0;
						done_d         = 1'b1;
					end else begin
						tick_count_b_d = cnt_b_inc;
					end
				end
			end
			qtpm_pkg::CMD_TIMER: begin
				// no rising A edge since the last timer tick: report a stall
				if (alive_q) begin
					alive_d = 1'b0;
				end else begin
					period_a_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q  <= '0;
			levels_valid_q <= 1'b0;
			dir_bits_q     <= qtpm_pkg::DIR_RESET;
			tick_count_a_q <= '0;
			tick_count_b_q <= '0;
			rev_start_a_q  <= '0;
			rev_start_b_q  <= '0;
			started_a_q    <= 1'b0;
			started_b_q    <= 1'b0;
			period_a_q     <= '0;
			period_b_q     <= '0;
			alive_q        <= 1'b0;
		end else if (advance) begin
			prev_levels_q  <= prev_levels_d;
			levels_valid_q <= levels_valid_d;
			dir_bits_q     <= dir_bits_d;
			tick_count_a_q <= tick_count_a_d;
			tick_count_b_q <= tick_count_b_d;
			rev_start_a_q  <= rev_start_a_d;
			rev_start_b_q  <= rev_start_b_d;
			started_a_q    <= started_a_d;
			started_b_q    <= started_b_d;
			period_a_q     <= period_a_d;
			period_b_q     <= period_b_d;
			alive_q        <= alive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dir_e_q        <= dir_bits_d[0];
			dir_f_q        <= dir_bits_d[1];
			period_a_out_q <= period_a_d;
			period_b_out_q <= period_b_d;
			rev_done_q     <= done_d;
		end
	end

endmodule
